>>> rtl/rpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the rectangular/polar converter.
package rpc_pkg;

    // Angle width inside the CORDIC pipeline, in 1/2048 degree.
    localparam int ANG_W = 21;
    // Rotation datapath width: 16-bit input times 16-bit gain, plus CORDIC growth.
    localparam int ROT_W = 34;

    localparam logic [1:0] OP_RECT  = 2'd0;
    localparam logic [1:0] OP_POLAR = 2'd1;

    localparam logic [15:0]              GAIN_Q16     = 16'd39797;
    localparam logic signed [17:0]       GAIN_POS     = 18'sd39797;
    localparam logic signed [17:0]       GAIN_NEG     = -18'sd39797;
    localparam logic signed [ANG_W-1:0]  DEG90        = 21'sd184320;
    localparam logic signed [ANG_W-1:0]  DEG180       = 21'sd368640;
    localparam logic signed [16:0]       TURN_OUT     = 17'sd46080;
    localparam logic signed [16:0]       HALF_OUT     = 17'sd23040;
    localparam logic signed [16:0]       NEG_HALF_OUT = -17'sd23040;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic [15:0]        magnitude;
        logic signed [15:0] angle_out;
        logic               form_error;
    } t_out_word;

    // Control bits that travel with each pipeline stage.
    typedef struct packed {
        logic valid;
        logic form_error;
        logic rotate;
        logic zero;
    } t_ctl;

    // atan(2^-idx) in 1/2048 degree.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 21'sd92160;
            5'd1:    v = 21'sd54405;
            5'd2:    v = 21'sd28746;
            5'd3:    v = 21'sd14592;
            5'd4:    v = 21'sd7324;
            5'd5:    v = 21'sd3666;
            5'd6:    v = 21'sd1833;
            5'd7:    v = 21'sd917;
            5'd8:    v = 21'sd458;
            5'd9:    v = 21'sd229;
            5'd10:   v = 21'sd115;
            5'd11:   v = 21'sd57;
            5'd12:   v = 21'sd29;
            5'd13:   v = 21'sd14;
            5'd14:   v = 21'sd7;
            5'd15:   v = 21'sd4;
            5'd16:   v = 21'sd2;
            5'd17:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/rpc_rot_stage.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC iteration with its pipeline register.
module rpc_rot_stage #(
    parameter int IDX = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  rpc_pkg::t_ctl                         i_ctl,
    input  logic signed [rpc_pkg::ROT_W-1:0]      i_x,
    input  logic signed [rpc_pkg::ROT_W-1:0]      i_y,
    input  logic signed [rpc_pkg::ANG_W-1:0]      i_z,
    output rpc_pkg::t_ctl                         o_ctl,
    output logic signed [rpc_pkg::ROT_W-1:0]      o_x,
    output logic signed [rpc_pkg::ROT_W-1:0]      o_y,
    output logic signed [rpc_pkg::ANG_W-1:0]      o_z
);

    logic signed [rpc_pkg::ANG_W-1:0] w_atan;
    logic signed [rpc_pkg::ROT_W-1:0] w_dx;
    logic signed [rpc_pkg::ROT_W-1:0] w_dy;
    logic signed [rpc_pkg::ROT_W-1:0] n_x;
    logic signed [rpc_pkg::ROT_W-1:0] n_y;
    logic signed [rpc_pkg::ANG_W-1:0] n_z;
    rpc_pkg::t_ctl                    r_ctl;
    logic signed [rpc_pkg::ROT_W-1:0] r_x;
    logic signed [rpc_pkg::ROT_W-1:0] r_y;
    logic signed [rpc_pkg::ANG_W-1:0] r_z;

    assign w_atan = rpc_pkg::atan_entry(5'(IDX));
    assign w_dx   = i_y >>> IDX;
    assign w_dy   = i_x >>> IDX;

    // Rectangular items pass untouched.
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (i_ctl.rotate) begin
            if (i_z >= 0) begin
                n_x = i_x - w_dx;
                n_y = i_y + w_dy;
                n_z = i_z - w_atan;
            end else begin
                n_x = i_x + w_dx;
                n_y = i_y - w_dy;
                n_z = i_z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> rtl/rpc_vec_stage.sv
`timescale 1ns / 1ps
// One vectoring-mode CORDIC iteration with its pipeline register.
module rpc_vec_stage #(
    parameter int VW     = 35,
    parameter int PASS_W = 32,
    parameter int IDX    = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  rpc_pkg::t_ctl                         i_ctl,
    input  logic [PASS_W-1:0]                     i_pass,
    input  logic signed [VW-1:0]                  i_x,
    input  logic signed [VW-1:0]                  i_y,
    input  logic signed [rpc_pkg::ANG_W-1:0]      i_z,
    output rpc_pkg::t_ctl                         o_ctl,
    output logic [PASS_W-1:0]                     o_pass,
    output logic signed [VW-1:0]                  o_x,
    output logic signed [VW-1:0]                  o_y,
    output logic signed [rpc_pkg::ANG_W-1:0]      o_z
);

    logic signed [rpc_pkg::ANG_W-1:0] w_atan;
    logic signed [VW-1:0]             w_dx;
    logic signed [VW-1:0]             w_dy;
    logic signed [VW-1:0]             n_x;
    logic signed [VW-1:0]             n_y;
    logic signed [rpc_pkg::ANG_W-1:0] n_z;
    rpc_pkg::t_ctl                    r_ctl;
    logic [PASS_W-1:0]                r_pass;
    logic signed [VW-1:0]             r_x;
    logic signed [VW-1:0]             r_y;
    logic signed [rpc_pkg::ANG_W-1:0] r_z;

    assign w_atan = rpc_pkg::atan_entry(5'(IDX));
    assign w_dx   = i_y >>> IDX;
    assign w_dy   = i_x >>> IDX;

    // Drive y toward zero, accumulating the angle.
    always_comb begin
        if (i_y >= 0) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_atan;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass <= i_pass;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_pass = r_pass;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

>>> rtl/rpc_out_buf.sv
`timescale 1ns / 1ps
// Output register with a one-word skid stage; freezes the pipeline when the skid is full.
module rpc_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rpc_pkg::t_out_word  i_word,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_ready,
    output rpc_pkg::t_out_word  o_word
);

    logic               r_out_valid;
    logic               r_skid_valid;
    rpc_pkg::t_out_word r_out;
    rpc_pkg::t_out_word r_skid;
    logic               w_stalled;

    assign w_stalled = r_out_valid && !i_ready;
    assign o_advance = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_stalled) begin
            if (!r_skid_valid && i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stalled) begin
            if (!r_skid_valid) begin
                r_skid <= i_word;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= i_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

>>> rtl/rect_polar_converter_core.sv
`timescale 1ns / 1ps
// Top level of the pipelined CORDIC rectangular/polar converter.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle while o_in_ready is high: a form code with a rectangular (x, y) or
//   polar (magnitude, angle in 1/128 degree) vector. Output channel
//   (o_out_valid / i_out_ready / o_out_word) returns one word per input word,
//   in order: saturated x and y, magnitude and angle recomputed from x and
//   y, and a form error flag. Throughput is one word per clock while the
//   receiver does not stall. The accepting edge loads the input prep
//   register; the word then passes ITERATIONS rotation stages, saturation,
//   vectoring setup, ITERATIONS vectoring stages, gain multiply, rounding
//   and the output register, which raises o_out_valid.
//   Reset clears every valid bit; the output is empty and o_in_ready is
//   high in the first cycle after reset.
//   When the receiver stalls, one more word lands in the skid stage; then
//   o_in_ready drops and the whole pipeline holds until the skid drains.
//   o_in_ready is a register and never depends on i_out_ready in the same
//   cycle.
module rect_polar_converter_core #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rpc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rpc_pkg::t_out_word  o_out_word
);

    localparam int ROT_W  = rpc_pkg::ROT_W;
    localparam int ANG_W  = rpc_pkg::ANG_W;
    // x << 16, sign flip of the most negative x, and sqrt(2) * CORDIC gain.
    localparam int VEC_W  = COORD_WIDTH + 19;
    localparam int PASS_W = 2 * COORD_WIDTH;
    localparam int PROD_W = VEC_W - 1 + 16;
    localparam int PSUM_W = PROD_W + 1;
    localparam int RND_W  = ROT_W - 16;
    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (COORD_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    logic w_en;

    // ---------------------------------------------------------------
    // Input prep: reduce the polar angle, fold it into +-90 degrees,
    // scale the magnitude by the CORDIC gain. Rectangular words are
    // loaded as x << 16 / y << 16 and pass the rotation stages untouched.
    // ---------------------------------------------------------------
    logic signed [16:0]        n_b;
    logic signed [16:0]        n_b_red;
    logic signed [ANG_W-1:0]   n_z_raw;
    logic signed [17:0]        n_gain;
    rpc_pkg::t_ctl             n_p_ctl;
    logic signed [ROT_W-1:0]   n_p_x;
    logic signed [ROT_W-1:0]   n_p_y;
    logic signed [ANG_W-1:0]   n_p_z;
    rpc_pkg::t_ctl             r_p_ctl;
    logic signed [ROT_W-1:0]   r_p_x;
    logic signed [ROT_W-1:0]   r_p_y;
    logic signed [ANG_W-1:0]   r_p_z;

    always_comb begin
        n_b = 17'(i_in_word.second_value);
        if (n_b >= rpc_pkg::HALF_OUT) begin
            n_b_red = n_b - rpc_pkg::TURN_OUT;
        end else if (n_b < rpc_pkg::NEG_HALF_OUT) begin
            n_b_red = n_b + rpc_pkg::TURN_OUT;
        end else begin
            n_b_red = n_b;
        end
        n_z_raw = ANG_W'(n_b_red) <<< 4;

        n_p_ctl            = '0;
        n_p_ctl.valid      = i_in_valid;
        n_gain             = rpc_pkg::GAIN_POS;
        n_p_x              = '0;
        n_p_y              = '0;
        n_p_z              = '0;
        case (i_in_word.op)
            rpc_pkg::OP_RECT: begin
                n_p_x = ROT_W'(i_in_word.first_value) <<< 16;
                n_p_y = ROT_W'(i_in_word.second_value) <<< 16;
            end
            rpc_pkg::OP_POLAR: begin
                n_p_ctl.rotate = 1'b1;
                // Beyond +-90 degrees, rotate the opposite vector by angle -+ 180.
                if (n_z_raw > rpc_pkg::DEG90) begin
                    n_gain = rpc_pkg::GAIN_NEG;
                    n_p_z  = n_z_raw - rpc_pkg::DEG180;
                end else if (n_z_raw < -rpc_pkg::DEG90) begin
                    n_gain = rpc_pkg::GAIN_NEG;
                    n_p_z  = n_z_raw + rpc_pkg::DEG180;
                end else begin
                    n_p_z  = n_z_raw;
                end
                n_p_x = ROT_W'(i_in_word.first_value * n_gain);
            end
            default: begin
                // Invalid form: zero vector, flag the error.
                n_p_ctl.form_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (w_en) begin
            r_p_ctl <= n_p_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_x <= n_p_x;
            r_p_y <= n_p_y;
            r_p_z <= n_p_z;
        end
    end

    // ---------------------------------------------------------------
    // Rotation pipeline, one iteration per stage.
    // ---------------------------------------------------------------
    rpc_pkg::t_ctl           w_rot_ctl [ITERATIONS+1];
    logic signed [ROT_W-1:0] w_rot_x   [ITERATIONS+1];
    logic signed [ROT_W-1:0] w_rot_y   [ITERATIONS+1];
    logic signed [ANG_W-1:0] w_rot_z   [ITERATIONS+1];

    assign w_rot_ctl[0] = r_p_ctl;
    assign w_rot_x[0]   = r_p_x;
    assign w_rot_y[0]   = r_p_y;
    assign w_rot_z[0]   = r_p_z;

    for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_rot
        rpc_rot_stage #(
            .IDX (gi)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_rot_ctl[gi]),
            .i_x     (w_rot_x[gi]),
            .i_y     (w_rot_y[gi]),
            .i_z     (w_rot_z[gi]),
            .o_ctl   (w_rot_ctl[gi+1]),
            .o_x     (w_rot_x[gi+1]),
            .o_y     (w_rot_y[gi+1]),
            .o_z     (w_rot_z[gi+1])
        );
    end

    // ---------------------------------------------------------------
    // Round half up from the 16-bit fraction and saturate to COORD_WIDTH.
    // ---------------------------------------------------------------
    logic [ROT_W-1:0]              n_sum_x;
    logic [ROT_W-1:0]              n_sum_y;
    logic signed [RND_W-1:0]       n_rnd_x;
    logic signed [RND_W-1:0]       n_rnd_y;
    logic signed [32:0]            n_wide_x;
    logic signed [32:0]            n_wide_y;
    logic signed [32:0]            n_sat_x;
    logic signed [32:0]            n_sat_y;
    rpc_pkg::t_ctl                 n_s_ctl;
    rpc_pkg::t_ctl                 r_s_ctl;
    logic signed [COORD_WIDTH-1:0] r_s_x;
    logic signed [COORD_WIDTH-1:0] r_s_y;

    always_comb begin
        n_sum_x  = w_rot_x[ITERATIONS] + ROT_W'(32768);
        n_sum_y  = w_rot_y[ITERATIONS] + ROT_W'(32768);
        n_rnd_x  = n_sum_x[ROT_W-1:16];
        n_rnd_y  = n_sum_y[ROT_W-1:16];
        n_wide_x = 33'(n_rnd_x);
        n_wide_y = 33'(n_rnd_y);

        if (n_wide_x > SAT_HI) begin
            n_sat_x = SAT_HI;
        end else if (n_wide_x < SAT_LO) begin
            n_sat_x = SAT_LO;
        end else begin
            n_sat_x = n_wide_x;
        end
        if (n_wide_y > SAT_HI) begin
            n_sat_y = SAT_HI;
        end else if (n_wide_y < SAT_LO) begin
            n_sat_y = SAT_LO;
        end else begin
            n_sat_y = n_wide_y;
        end

        n_s_ctl      = w_rot_ctl[ITERATIONS];
        n_s_ctl.zero = (n_sat_x == 33'sd0) && (n_sat_y == 33'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ctl <= '0;
        end else if (w_en) begin
            r_s_ctl <= n_s_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_x <= n_sat_x[COORD_WIDTH-1:0];
            r_s_y <= n_sat_y[COORD_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Vectoring setup: move the vector into the right half plane.
    // ---------------------------------------------------------------
    logic signed [VEC_W-1:0] n_v_x;
    logic signed [VEC_W-1:0] n_v_y;
    logic signed [ANG_W-1:0] n_v_z;
    rpc_pkg::t_ctl           r_v_ctl;
    logic [PASS_W-1:0]       r_v_pass;
    logic signed [VEC_W-1:0] r_v_x;
    logic signed [VEC_W-1:0] r_v_y;
    logic signed [ANG_W-1:0] r_v_z;

    always_comb begin
        n_v_x = VEC_W'(r_s_x) <<< 16;
        n_v_y = VEC_W'(r_s_y) <<< 16;
        n_v_z = '0;
        if (r_s_x < 0) begin
            n_v_x = -n_v_x;
            n_v_y = -n_v_y;
            n_v_z = rpc_pkg::DEG180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_ctl <= '0;
        end else if (w_en) begin
            r_v_ctl <= r_s_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v_pass <= {r_s_x, r_s_y};
            r_v_x    <= n_v_x;
            r_v_y    <= n_v_y;
            r_v_z    <= n_v_z;
        end
    end

    // ---------------------------------------------------------------
    // Vectoring pipeline; x and y ride along for the output word.
    // ---------------------------------------------------------------
    rpc_pkg::t_ctl           w_vec_ctl  [ITERATIONS+1];
    logic [PASS_W-1:0]       w_vec_pass [ITERATIONS+1];
    logic signed [VEC_W-1:0] w_vec_x    [ITERATIONS+1];
    logic signed [VEC_W-1:0] w_vec_y    [ITERATIONS+1];
    logic signed [ANG_W-1:0] w_vec_z    [ITERATIONS+1];

    assign w_vec_ctl[0]  = r_v_ctl;
    assign w_vec_pass[0] = r_v_pass;
    assign w_vec_x[0]    = r_v_x;
    assign w_vec_y[0]    = r_v_y;
    assign w_vec_z[0]    = r_v_z;

    for (genvar gv = 0; gv < ITERATIONS; gv++) begin : g_vec
        rpc_vec_stage #(
            .VW     (VEC_W),
            .PASS_W (PASS_W),
            .IDX    (gv)
        ) u_vec (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_vec_ctl[gv]),
            .i_pass  (w_vec_pass[gv]),
            .i_x     (w_vec_x[gv]),
            .i_y     (w_vec_y[gv]),
            .i_z     (w_vec_z[gv]),
            .o_ctl   (w_vec_ctl[gv+1]),
            .o_pass  (w_vec_pass[gv+1]),
            .o_x     (w_vec_x[gv+1]),
            .o_y     (w_vec_y[gv+1]),
            .o_z     (w_vec_z[gv+1])
        );
    end

    // ---------------------------------------------------------------
    // Gain multiply for the magnitude; round the angle to 1/128 degree.
    // The vectored x is never negative.
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]       n_prod;
    logic [ANG_W-1:0]        n_zr;
    logic signed [ANG_W-5:0] n_ang;
    rpc_pkg::t_ctl           r_m_ctl;
    logic [PASS_W-1:0]       r_m_pass;
    logic [PROD_W-1:0]       r_m_prod;
    logic signed [ANG_W-5:0] r_m_ang;

    always_comb begin
        n_prod = PROD_W'(w_vec_x[ITERATIONS][VEC_W-2:0]) * PROD_W'(rpc_pkg::GAIN_Q16);
        n_zr   = w_vec_z[ITERATIONS] + ANG_W'(8);
        n_ang  = n_zr[ANG_W-1:4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else if (w_en) begin
            r_m_ctl <= w_vec_ctl[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_pass <= w_vec_pass[ITERATIONS];
            r_m_prod <= n_prod;
            r_m_ang  <= n_ang;
        end
    end

    // ---------------------------------------------------------------
    // Final stage: round and clamp the magnitude, wrap the angle into
    // (-180, 180] degrees, zero both for a zero vector.
    // ---------------------------------------------------------------
    logic [PSUM_W-1:0]             n_psum;
    logic [PSUM_W-33:0]            n_mag_w;
    logic signed [17:0]            n_ang18;
    logic signed [17:0]            n_wrap;
    logic signed [COORD_WIDTH-1:0] n_fx;
    logic signed [COORD_WIDTH-1:0] n_fy;
    rpc_pkg::t_out_word            n_f_word;
    logic                          r_f_valid;
    rpc_pkg::t_out_word            r_f_word;

    always_comb begin
        n_psum  = PSUM_W'(r_m_prod) + PSUM_W'(64'h0000_0000_8000_0000);
        n_mag_w = n_psum[PSUM_W-1:32];
        n_ang18 = 18'(r_m_ang);
        if (n_ang18 > 18'(rpc_pkg::HALF_OUT)) begin
            n_wrap = n_ang18 - 18'(rpc_pkg::TURN_OUT);
        end else if (n_ang18 <= 18'(rpc_pkg::NEG_HALF_OUT)) begin
            n_wrap = n_ang18 + 18'(rpc_pkg::TURN_OUT);
        end else begin
            n_wrap = n_ang18;
        end
        n_fx = r_m_pass[PASS_W-1:COORD_WIDTH];
        n_fy = r_m_pass[COORD_WIDTH-1:0];

        n_f_word.x_out      = 16'(n_fx);
        n_f_word.y_out      = 16'(n_fy);
        n_f_word.form_error = r_m_ctl.form_error;
        if (r_m_ctl.zero) begin
            n_f_word.magnitude = '0;
            n_f_word.angle_out = '0;
        end else begin
            if (64'(n_mag_w) > 64'd65535) begin
                n_f_word.magnitude = 16'hFFFF;
            end else begin
                n_f_word.magnitude = 16'(n_mag_w);
            end
            n_f_word.angle_out = 16'(n_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_m_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_word <= n_f_word;
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid stage; advance the pipeline while the
    // skid is free.
    // ---------------------------------------------------------------
    rpc_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_f_valid),
        .i_word    (r_f_word),
        .o_advance (w_en),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out_word)
    );

    assign o_in_ready = w_en;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined CORDIC rectangular/polar converter core.
module tb_top;
    import rpc_pkg::*;

    localparam int ITERATIONS      = 16;
    localparam int COORD_WIDTH     = 16;
    // Accepting edge to output valid.
    localparam int LATENCY         = 2 * ITERATIONS + 5;
    localparam int RANDOM_WORDS    = 400;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int HOLD_OFF_WORDS  = 80;
    localparam int MAX_REPORTS     = 10;

    // Form codes the package leaves unnamed: both must raise the error flag.
    localparam logic [1:0] OP_BAD_LO = 2'd2;
    localparam logic [1:0] OP_BAD_HI = 2'd3;

    // Predictor constants. Internal angles are in 1/2048 degree, output
    // angles in 1/128 degree, coordinates carry 16 fractional bits.
    localparam longint ROT_GAIN     = 39797;
    localparam longint QUARTER_TURN = 184320;
    localparam longint HALF_TURN    = 368640;
    localparam longint OUT_TURN     = 46080;
    localparam longint OUT_HALF     = 23040;
    localparam longint COORD_MAX    = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam longint MAG_ROUND    = longint'(1) << 31;
    localparam longint MAG_MAX      = 65535;

    localparam t_out_word ZERO_WORD     = '0;
    // Only the error flag set; it is the least significant bit of the word.
    localparam t_out_word FORM_ERR_WORD = t_out_word'(1);

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    typedef struct packed {
        t_in_word  stim;
        logic      known;
        t_out_word answer;
    } t_case_row;

    typedef struct packed {
        t_in_word  stim;
        t_out_word answer;
    } t_awaited;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    // Words accepted by the core whose results have not come back yet, oldest first.
    t_awaited awaited_words[$];

    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  rect_words     = 0;
    int  polar_words    = 0;
    int  bad_words      = 0;
    // Set by the stimulus side to make the receiver hold off for a long stretch.
    bit  hold_off_req   = 1'b0;

    rect_polar_converter_core #(
        .ITERATIONS  (ITERATIONS),
        .COORD_WIDTH (COORD_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // atan(2^-k) in 1/2048 degree; zero past step 17.
    function automatic longint atan_step(input int k);
        case (k)
            0:       return 92160;
            1:       return 54405;
            2:       return 28746;
            3:       return 14592;
            4:       return 7324;
            5:       return 3666;
            6:       return 1833;
            7:       return 917;
            8:       return 458;
            9:       return 229;
            10:      return 115;
            11:      return 57;
            12:      return 29;
            13:      return 14;
            14:      return 7;
            15:      return 4;
            16:      return 2;
            17:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // Compute the result word the core must return for one input word.
    function automatic t_out_word convert_vector(input t_in_word w);
        t_out_word r;
        longint    a, b, x, y, z, cx, cy, dx, dy, vx, vy, mag, ang;
        r = ZERO_WORD;
        if (w.op != OP_RECT && w.op != OP_POLAR)
            return FORM_ERR_WORD;
        a   = w.first_value;
        b   = w.second_value;
        mag = 0;
        ang = 0;
        if (w.op == OP_RECT) begin
            x = clamp_coord(a);
            y = clamp_coord(b);
        end else begin
            // Fold the angle into one turn, then into +-90 degrees by
            // flipping the magnitude.
            if (b >= OUT_HALF)
                b -= OUT_TURN;
            else if (b < -OUT_HALF)
                b += OUT_TURN;
            z  = b * 16;
            cx = a * ROT_GAIN;
            if (z > QUARTER_TURN) begin
                cx = -cx;
                z -= HALF_TURN;
            end else if (z < -QUARTER_TURN) begin
                cx = -cx;
                z += HALF_TURN;
            end
            cy = 0;
            for (int i = 0; i < ITERATIONS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0) begin
                    cx -= dx;
                    cy += dy;
                    z  -= atan_step(i);
                end else begin
                    cx += dx;
                    cy -= dy;
                    z  += atan_step(i);
                end
            end
            x = clamp_coord((cx + 32768) >>> 16);
            y = clamp_coord((cy + 32768) >>> 16);
        end
        if (x != 0 || y != 0) begin
            vx = x * 65536;
            vy = y * 65536;
            z  = 0;
            if (vx < 0) begin
                vx = -vx;
                vy = -vy;
                z  = HALF_TURN;
            end
            for (int i = 0; i < ITERATIONS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx += dx;
                    vy -= dy;
                    z  += atan_step(i);
                end else begin
                    vx -= dx;
                    vy += dy;
                    z  -= atan_step(i);
                end
            end
            mag = (vx * ROT_GAIN + MAG_ROUND) >>> 32;
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            if (mag < 0)
                mag = 0;
            ang = (z + 8) >>> 4;
            while (ang > OUT_HALF)
                ang -= OUT_TURN;
            while (ang <= -OUT_HALF)
                ang += OUT_TURN;
        end
        r.x_out      = 16'(x);
        r.y_out      = 16'(y);
        r.magnitude  = 16'(mag);
        r.angle_out  = 16'(ang);
        r.form_error = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_case_row case_row(input logic [1:0] op, input int a, input int b,
                                           input logic known, input t_out_word answer);
        t_case_row r;
        r.stim.op           = op;
        r.stim.first_value  = 16'(a);
        r.stim.second_value = 16'(b);
        r.known             = known;
        r.answer            = answer;
        return r;
    endfunction

    // Coordinate or magnitude: extremes, small values near the origin, or anything.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            1, 2:    return 16'(int'($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Polar angle: near a multiple of 22.5 degrees (folding and wrap edges) or anything,
    // which also covers angles outside one turn.
    function automatic logic signed [15:0] pick_angle();
        int k;
        k = int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 3) == 0)
            return 16'(k * 2880 + int'($urandom_range(0, 4)) - 2);
        return 16'($urandom);
    endfunction

    function automatic t_in_word random_vector();
        t_in_word w;
        int       pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            w.op = OP_RECT;
        else if (pick < 18)
            w.op = OP_POLAR;
        else
            w.op = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
        w.first_value  = pick_coord();
        w.second_value = (w.op == OP_POLAR) ? pick_angle() : pick_coord();
        return w;
    endfunction

    // Offer one word at the falling edge and hold it until a rising edge sees ready;
    // record the expected result at that edge.
    task automatic send_word(input t_in_word w, input t_out_word answer);
        t_awaited e;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        e.stim   = w;
        e.answer = answer;
        awaited_words.push_back(e);
        if (w.op == OP_RECT)
            rect_words++;
        else if (w.op == OP_POLAR)
            polar_words++;
        else
            bad_words++;
    endtask

    // Drop valid for a gap set by n; put junk on the payload so an idle bus is exercised.
    task automatic pause_sender(input int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_in_word  <= t_in_word'({$urandom, $urandom});
        repeat (n) @(posedge i_clk);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic idle_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        mode        = RX_OPEN;
        mode_left   = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                // Hold off: the pipeline fills, the skid stage takes one more word,
                // then the core must drop its input ready.
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_awaited head;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result word with nothing outstanding: x=%0d y=%0d",
                             $time, o_out_word.x_out, o_out_word.y_out);
            end else begin
                head = awaited_words.pop_front();
                checked_count++;
                if (o_out_word.x_out      !== head.answer.x_out     ||
                    o_out_word.y_out      !== head.answer.y_out     ||
                    o_out_word.magnitude  !== head.answer.magnitude ||
                    o_out_word.angle_out  !== head.answer.angle_out ||
                    o_out_word.form_error !== head.answer.form_error) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: op=%0d in=(%0d, %0d)", $time, head.stim.op,
                                 head.stim.first_value, head.stim.second_value);
                        $display("    expected x=%0d y=%0d mag=%0d ang=%0d err=%0b",
                                 head.answer.x_out, head.answer.y_out,
                                 head.answer.magnitude, head.answer.angle_out,
                                 head.answer.form_error);
                        $display("    actual   x=%0d y=%0d mag=%0d ang=%0d err=%0b",
                                 o_out_word.x_out, o_out_word.y_out,
                                 o_out_word.magnitude, o_out_word.angle_out,
                                 o_out_word.form_error);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_case_row rows[$];
        int        sent;
        int        burst;
        bit        held;
        bit        drained;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words. Answers are typed in only where they are plain:
        // the zero vector and the invalid form codes.
        rows.push_back(case_row(OP_RECT,   0,      0,      1'b1, ZERO_WORD));
        rows.push_back(case_row(OP_BAD_LO, 1234,   -5678,  1'b1, FORM_ERR_WORD));
        rows.push_back(case_row(OP_BAD_HI, -32768, 32767,  1'b1, FORM_ERR_WORD));
        rows.push_back(case_row(OP_POLAR,  0,      5000,   1'b1, ZERO_WORD));
        // Corners of the coordinate range and unit steps on and next to the axes.
        rows.push_back(case_row(OP_RECT,   32767,  32767,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   -32768, -32768, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   32767,  -32768, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   -32768, 32767,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   1,      0,      1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   0,      -1,     1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   -1,     0,      1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_RECT,   -300,   1,      1'b0, ZERO_WORD));
        // Polar: axes, just past 90 degrees, negative magnitude, wrap edges, 45 and 135 degrees.
        rows.push_back(case_row(OP_POLAR,  32767,  0,      1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  32767,  11520,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  32767,  -11520, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  32767,  11521,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  -32768, 0,      1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  20000,  23040,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  20000,  -23041, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  20000,  -23040, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  20000,  32767,  1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  20000,  -32768, 1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  32767,  5760,   1'b0, ZERO_WORD));
        rows.push_back(case_row(OP_POLAR,  1,      17280,  1'b0, ZERO_WORD));

        foreach (rows[k])
            send_word(rows[k].stim,
                      rows[k].known ? rows[k].answer : convert_vector(rows[k].stim));
        idle_until_drained();

        // Random words in bursts with random gaps; some bursts run back to back.
        sent    = 0;
        held    = 1'b0;
        drained = 1'b0;
        while (sent < RANDOM_WORDS) begin
            if (!held && sent >= 150) begin
                // Keep offering words while the receiver holds off, so the core
                // fills up and stalls its input.
                held         = 1'b1;
                hold_off_req = 1'b1;
                repeat (HOLD_OFF_WORDS) begin
                    t_in_word hw;
                    hw = random_vector();
                    send_word(hw, convert_vector(hw));
                end
                sent += HOLD_OFF_WORDS;
            end
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                t_in_word w;
                w = random_vector();
                send_word(w, convert_vector(w));
            end
            sent += burst;
            if (!drained && sent >= 280) begin
                drained = 1'b1;
                idle_until_drained();
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end

        idle_until_drained();
        // Give any stray result time to show up.
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Covered %0d rectangular, %0d polar and %0d invalid-form words,",
                 rect_words, polar_words, bad_words);
        $display("with %0d results compared and %0d mismatches.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
